>>> design/skf_pkg.sv
// Shared types, widths, register indexes and reset values for the scalar Kalman filter.
package skf_pkg;

  localparam int DATA_W   = 32;
  localparam int GAIN_W   = 17;
  localparam int GAIN_FRAC = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_STEPS = GAIN_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int PROD_W    = DATA_W + 1 + GAIN_W;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OBS_VARIANCE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PROC_VARIANCE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INIT_ESTIMATE  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INIT_ERROR_VAR = CFG_IDX_W'(3);

  // Reset values of the configuration registers.
  localparam logic [DATA_W-1:0] RST_OBS_VARIANCE   = 32'd65536;
  localparam logic [DATA_W-1:0] RST_PROC_VARIANCE  = 32'd655;
  localparam logic [DATA_W-1:0] RST_INIT_ESTIMATE  = 32'd0;
  localparam logic [DATA_W-1:0] RST_INIT_ERROR_VAR = 32'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIOR,
    ST_SETUP,
    ST_DIV,
    ST_MUL_EST,
    ST_MUL_VAR,
    ST_FINISH
  } skf_state_t;

endpackage

>>> design/skf_if.sv
// Valid/ready channel interfaces for observations and filter results.
interface skf_obs_if import skf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] observation;
  logic                     restart;

  modport source (output valid, output observation, output restart, input ready);
  modport sink   (input valid, input observation, input restart, output ready);
endinterface

interface skf_res_if import skf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] estimate;
  logic [GAIN_W-1:0]        gain;
  logic [DATA_W-1:0]        error_variance;

  modport source (output valid, output estimate, output gain, output error_variance,
                  input ready);
  modport sink   (input valid, input estimate, input gain, input error_variance,
                  output ready);
endinterface

>>> design/scalar_kalman_filter.sv
// Scalar Kalman filter: one predict/update step per observation on a shared divider and multiplier.
//
// Each observation transaction runs one predict/update step of a one-dimensional
// constant-state Kalman filter. The process variance Q is added to the error
// variance (saturating), the gain K = P/(P+R) is formed as an unsigned Q1.16
// value rounded toward zero, the estimate moves by K times the innovation, and
// the variance is scaled by (1-K). A set restart bit reloads the estimate and
// variance from the init registers before the step. The observation is captured
// in the cycle in which it is accepted; then come, in order, the setup states
// (prior variance and innovation, then the divisor), the restoring divider that
// produces one gain bit per cycle, the correction and then the new variance on
// the single 33x17 multiplier, and the commit to the result register, which
// waits while that register holds a result that is not being taken. The input
// is not ready while a step is in progress; the result sits in an output
// register, so the next observation is taken as soon as the result has been
// loaded there, even if it has not yet been consumed. Configuration writes
// must only happen while the filter is idle; new R and Q take effect on the
// next step, new initial values only on a restart.
module scalar_kalman_filter import skf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  skf_obs_if.sink              obs,
  skf_res_if.source            res
);

  // Configuration registers.
  logic [DATA_W-1:0] obs_variance;
  logic [DATA_W-1:0] proc_variance;
  logic [DATA_W-1:0] init_estimate;
  logic [DATA_W-1:0] init_error_var;

  // Filter state.
  logic [DATA_W-1:0] est_reg;
  logic [DATA_W-1:0] var_reg;

  // Sequencer.
  skf_state_t        state;
  skf_state_t        state_next;
  logic [CNT_W-1:0]  cnt;

  // Working registers of one step.
  logic [DATA_W-1:0] obs_r;
  logic [DATA_W-1:0] pm;
  logic [DATA_W:0]   diff;
  logic [DATA_W:0]   denom;
  logic [DATA_W:0]   mag;
  logic              neg;
  logic [DATA_W:0]   rem;
  logic [GAIN_W-1:0] nbits;
  logic [GAIN_W-1:0] quo;
  logic [GAIN_W-1:0] k;
  logic [PROD_W-1:0] prod;
  logic [DATA_W-1:0] est_new;

  // Result register.
  logic              res_valid;
  logic [DATA_W-1:0] res_est;
  logic [GAIN_W-1:0] res_gain;
  logic [DATA_W-1:0] res_var;

  // Combinational helpers.
  logic              accept;
  logic              res_free;
  logic              do_commit;
  logic [DATA_W:0]   pm_sum;
  logic [DATA_W+1:0] trial;
  logic              ge;
  logic [DATA_W+1:0] trial_sub;
  logic [DATA_W:0]   mul_a;
  logic [GAIN_W-1:0] mul_b;
  logic [DATA_W:0]   corr;
  logic [DATA_W+1:0] est_sum;

  assign accept    = obs.valid && obs.ready;
  assign res_free  = !res_valid || res.ready;

  assign pm_sum    = {1'b0, var_reg} + {1'b0, proc_variance};
  assign trial     = {rem, nbits[GAIN_W-1]};
  assign ge        = trial >= {1'b0, denom};
  assign trial_sub = trial - {1'b0, denom};

  // The correction is the magnitude times the gain with the fraction dropped;
  // it never exceeds the innovation magnitude, so 33 bits hold it.
  assign corr    = prod[GAIN_FRAC +: DATA_W+1];
  assign est_sum = neg ? ({{2{est_reg[DATA_W-1]}}, est_reg} - {1'b0, corr})
                       : ({{2{est_reg[DATA_W-1]}}, est_reg} + {1'b0, corr});

  // Sequencer: next state, input ready, commit and the operand select of the shared multiplier.
  always_comb begin
    state_next = state;
    do_commit  = 1'b0;
    mul_a      = mag;
    mul_b      = k;
    obs.ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        obs.ready = 1'b1;
        if (obs.valid) begin
          state_next = ST_PRIOR;
        end
      end
      ST_PRIOR:   state_next = ST_SETUP;
      ST_SETUP:   state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_MUL_EST;
        end
      end
      ST_MUL_EST: state_next = ST_MUL_VAR;
      ST_MUL_VAR: begin
        mul_a      = {1'b0, pm};
        mul_b      = GAIN_ONE - k;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (res_free) begin
          do_commit  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      obs_variance   <= RST_OBS_VARIANCE;
      proc_variance  <= RST_PROC_VARIANCE;
      init_estimate  <= RST_INIT_ESTIMATE;
      init_error_var <= RST_INIT_ERROR_VAR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OBS_VARIANCE:   obs_variance   <= cfg_data;
        REG_PROC_VARIANCE:  proc_variance  <= cfg_data;
        REG_INIT_ESTIMATE:  init_estimate  <= cfg_data;
        REG_INIT_ERROR_VAR: init_error_var <= cfg_data;
        default: ;
      endcase
    end
  end

  // Filter state: reloaded on reset or on a restart observation, and updated
  // when a finished step is committed to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      est_reg <= RST_INIT_ESTIMATE;
      var_reg <= RST_INIT_ERROR_VAR;
    end else if (accept && obs.restart) begin
      est_reg <= init_estimate;
      var_reg <= init_error_var;
    end else if (do_commit) begin
      est_reg <= est_new;
      var_reg <= prod[GAIN_FRAC +: DATA_W];
    end
  end

  // Datapath of one step.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        obs_r <= obs.observation;
      end
      ST_PRIOR: begin
        // Prior variance saturates; the innovation is formed at 33 bits.
        pm   <= pm_sum[DATA_W] ? '1 : pm_sum[DATA_W-1:0];
        diff <= {obs_r[DATA_W-1], obs_r} - {est_reg[DATA_W-1], est_reg};
      end
      ST_SETUP: begin
        denom <= {1'b0, pm} + {1'b0, obs_variance};
        neg   <= diff[DATA_W];
        mag   <= diff[DATA_W] ? (~diff + 1'b1) : diff;
        // The dividend is pm shifted up by the gain fraction; its upper part
        // seeds the remainder and the last 17 bits are shifted in one a cycle.
        rem   <= {1'b0, pm} >> 1;
        nbits <= {pm[0], {(GAIN_W-1){1'b0}}};
        quo   <= '0;
        cnt   <= '0;
      end
      ST_DIV: begin
        rem   <= ge ? trial_sub[DATA_W:0] : trial[DATA_W:0];
        quo   <= {quo[GAIN_W-2:0], ge};
        nbits <= nbits << 1;
        cnt   <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          // A zero denominator means both variances are zero: no gain.
          k <= (denom == '0) ? '0 : {quo[GAIN_W-2:0], ge};
        end
      end
      ST_MUL_EST: begin
        prod <= mul_a * mul_b;
      end
      ST_MUL_VAR: begin
        est_new <= est_sum[DATA_W-1:0];
        prod    <= mul_a * mul_b;
      end
      default: ;
    endcase
  end

  // Result register: loaded on commit, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (do_commit) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_commit) begin
      res_est  <= est_new;
      res_gain <= k;
      res_var  <= prod[GAIN_FRAC +: DATA_W];
    end
  end

  assign res.valid          = res_valid;
  assign res.estimate       = res_est;
  assign res.gain           = res_gain;
  assign res.error_variance = res_var;

endmodule

>>> design/skf_checker.sv
// Port-level assertions for the scalar Kalman filter and their bind.
module skf_checker import skf_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [GAIN_W-1:0] out_gain,
  input logic [DATA_W-1:0] out_var
);

  // A result that is not taken stays offered unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_var) && $stable(out_gain)))
    else $error("stalled result changed");

  // A step is in progress after each transaction, so the input closes right after it.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready again right after a transaction");

  // The gain is a fraction in 0..1.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_gain <= GAIN_ONE))
    else $error("gain above one");

  // No result can be offered just after reset.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (obs.valid),
  .in_ready  (obs.ready),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .out_gain  (res.gain),
  .out_var   (res.error_variance)
);

>>> bench/tb.sv
// Self-checking testbench for the scalar Kalman filter with its own fixed-point predictor.
//
// The bench drives observation transactions into the filter over the valid/ready
// channel and checks every result transaction against a predictor that models the
// filter bit for bit. The predictor keeps its own copy of the estimate, the error
// variance and the four configuration registers. It is stepped once for every
// accepted observation, and its result is queued until the matching result
// transaction comes out of the filter. Results are checked in order, field by
// field, by a monitor process that also drives the result-side ready.
//
// The test sequence is a set of named tasks called in turn:
//   - reset defaults: extreme observations and a restart under the reset configuration,
//   - configuration extremes: ignored writes to unused indexes, a gain of exactly one,
//     the zero-denominator case, saturation of the prior variance, the largest
//     innovations, and initial values that must not apply without a restart,
//   - random tracking: phases with random configuration in which noisy readings of a
//     slowly moving true value are mixed with full-range noise and random restarts,
//   - back-pressure: the result side holds off for a long stretch while observations
//     keep coming, so that the filter fills up and stalls its input,
//   - full rate: no sender gaps and no receiver stalls.
// Configuration is only rewritten once every expected result has been received.
module tb;
  import skf_pkg::*;

  // One result transaction as the predictor expects it.
  typedef struct packed {
    logic signed [DATA_W-1:0] estimate;
    logic [GAIN_W-1:0]        gain;
    logic [DATA_W-1:0]        error_variance;
  } kf_result_t;

  // Ways in which the result side throttles the filter.
  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  localparam logic signed [DATA_W-1:0] EST_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] EST_MIN = 32'sh8000_0000;
  localparam logic [DATA_W-1:0]        VAR_MAX = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0]        VAR_ONE = 32'd65536;

  // Length of one step, counting the accepting cycle, until its result register loads.
  localparam int STEP_CYCLES = 23;
  // Length of the long result-side hold in the back-pressure test.
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 150;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  skf_obs_if obs_ch ();
  skf_res_if res_ch ();

  scalar_kalman_filter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .obs       (obs_ch),
    .res       (res_ch)
  );

  // Predictor copy of the configuration registers and of the filter state.
  logic [DATA_W-1:0]        obs_var_cfg;
  logic [DATA_W-1:0]        proc_var_cfg;
  logic signed [DATA_W-1:0] init_est_cfg;
  logic [DATA_W-1:0]        init_var_cfg;
  logic signed [DATA_W-1:0] est_state;
  logic [DATA_W-1:0]        var_state;

  // Expected results, oldest first.
  kf_result_t estimates_due[$];
  int         fail_count = 0;

  // Sender burst control, and receiver throttling shared with the result monitor.
  int       burst_left = 0;
  int       max_gap = 0;
  bit       offering = 1'b0;
  rx_mode_t rx_mode = RX_ALWAYS;
  int       hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a generous bound on the slowest correct run.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // One predict/update step of the filter. The prior variance saturates at 32 bits,
  // the gain is floor(P*2^16/(P+R)) with zero for a zero denominator, the correction
  // is truncated toward zero on its magnitude, and the variance is scaled by (1-K).
  function automatic kf_result_t kalman_update(input logic signed [DATA_W-1:0] reading,
                                               input logic reload);
    kf_result_t  upd;
    logic [63:0] prior, denom, k, mag, corr, post_var;
    longint      est, innov, next_est;
    if (reload) begin
      est_state = init_est_cfg;
      var_state = init_var_cfg;
    end
    prior = 64'(var_state) + 64'(proc_var_cfg);
    if (prior > 64'(VAR_MAX)) begin
      prior = 64'(VAR_MAX);
    end
    denom = prior + 64'(obs_var_cfg);
    k = (denom == 64'd0) ? 64'd0 : (prior << GAIN_FRAC) / denom;
    est = longint'(est_state);
    innov = longint'(reading) - est;
    mag = (innov < 0) ? 64'(-innov) : 64'(innov);
    corr = (mag * k) >> GAIN_FRAC;
    next_est = (innov < 0) ? est - longint'(corr) : est + longint'(corr);
    post_var = ((64'(GAIN_ONE) - k) * prior) >> GAIN_FRAC;
    est_state = DATA_W'(next_est);
    var_state = post_var[DATA_W-1:0];
    upd.estimate = est_state;
    upd.gain = k[GAIN_W-1:0];
    upd.error_variance = var_state;
    return upd;
  endfunction

  // Predictor image of a reset: registers back to their reset values, state reloaded.
  task automatic reset_model();
    obs_var_cfg = RST_OBS_VARIANCE;
    proc_var_cfg = RST_PROC_VARIANCE;
    init_est_cfg = RST_INIT_ESTIMATE;
    init_var_cfg = RST_INIT_ERROR_VAR;
    est_state = init_est_cfg;
    var_state = init_var_cfg;
  endtask

  // Writes one register and leaves the write enable high; the caller lowers it once
  // its run of writes is done, so the enable never gets two updates in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_OBS_VARIANCE:   obs_var_cfg = data;
      REG_PROC_VARIANCE:  proc_var_cfg = data;
      REG_INIT_ESTIMATE:  init_est_cfg = data;
      REG_INIT_ERROR_VAR: init_var_cfg = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [DATA_W-1:0] r_val, input logic [DATA_W-1:0] q_val,
                            input logic [DATA_W-1:0] est0, input logic [DATA_W-1:0] var0);
    write_reg(REG_OBS_VARIANCE, r_val);
    write_reg(REG_PROC_VARIANCE, q_val);
    write_reg(REG_INIT_ESTIMATE, est0);
    write_reg(REG_INIT_ERROR_VAR, var0);
    cfg_we <= 1'b0;
  endtask

  // Offers one observation and returns in the step at which it was accepted. The
  // sender works in bursts; between bursts it drops valid for a random gap. Valid is
  // left high after acceptance, so it stays high across back-to-back transactions.
  task automatic send_obs(input logic signed [DATA_W-1:0] reading, input logic reload);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        if (offering) begin
          obs_ch.valid <= 1'b0;
          offering = 1'b0;
        end
        repeat (gap) @(posedge clk);
      end
    end
    obs_ch.valid <= 1'b1;
    obs_ch.observation <= reading;
    obs_ch.restart <= reload;
    offering = 1'b1;
    do @(posedge clk); while (!obs_ch.ready);
    estimates_due.push_back(kalman_update(reading, reload));
    burst_left--;
  endtask

  // Stops offering and waits until every expected result has been received.
  task automatic drain_results();
    if (offering) begin
      obs_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    burst_left = 0;
    while (estimates_due.size() != 0) @(posedge clk);
  endtask

  // Variance register values that favor the corners: zero, all ones, small, near one.
  function automatic logic [DATA_W-1:0] pick_variance();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return VAR_MAX;
      2: return DATA_W'($urandom_range(0, 1 << 16));
      3: return DATA_W'($urandom_range(1 << 12, 1 << 22));
      default: return $urandom;
    endcase
  endfunction

  // A noisy sensor reading of the true value; now and then pure full-range noise.
  function automatic logic signed [DATA_W-1:0] next_reading(
      input logic signed [DATA_W-1:0] truth);
    int unsigned amp;
    if ($urandom_range(0, 99) < 15) begin
      return $urandom;
    end
    amp = 1 << $urandom_range(0, 24);
    return DATA_W'(longint'(truth) + longint'($urandom_range(0, 2 * amp)) - longint'(amp));
  endfunction

  // Observations of the extremes under the reset configuration, and one restart.
  task automatic test_reset_defaults();
    rx_mode = RX_RANDOM;
    max_gap = 3;
    send_obs('0, 1'b0);
    send_obs(EST_MAX, 1'b0);
    send_obs(EST_MIN, 1'b0);
    send_obs(EST_MIN, 1'b1);
    send_obs($urandom, 1'b0);
    drain_results();
  endtask

  task automatic test_config_extremes();
    int idx;
    rx_mode = RX_PERIODIC;
    max_gap = 2;
    // Writes to indexes past the last register must leave every register as it is.
    for (idx = int'(REG_INIT_ERROR_VAR) + 1; idx < (1 << CFG_IDX_W); idx++) begin
      write_reg(CFG_IDX_W'(idx), $urandom);
    end
    cfg_we <= 1'b0;
    send_obs(32'sh0003_0000, 1'b0);
    drain_results();

    // With R at zero the gain is exactly one: the estimate jumps to the observation
    // and the variance collapses to zero.
    set_config('0, RST_PROC_VARIANCE, RST_INIT_ESTIMATE, VAR_ONE);
    send_obs(32'sh1234_5678, 1'b1);
    send_obs(-32'sh0070_0000, 1'b0);
    drain_results();

    // P+R is zero: the gain is zero, so even the largest innovation leaves the
    // estimate where it is and the variance stays zero.
    set_config('0, '0, EST_MAX, '0);
    send_obs(EST_MIN, 1'b1);
    send_obs('0, 1'b0);
    drain_results();

    // The prior variance saturates at all ones, and the innovation spans the full range.
    set_config(32'd1, VAR_MAX, EST_MIN, VAR_MAX);
    send_obs(EST_MAX, 1'b1);
    send_obs(EST_MIN, 1'b0);
    drain_results();

    // Largest R with a zero prior, then largest everything.
    set_config(VAR_MAX, '0, EST_MAX, '0);
    send_obs(EST_MAX, 1'b1);
    drain_results();
    set_config(VAR_MAX, VAR_MAX, EST_MAX, VAR_MAX);
    send_obs(EST_MIN, 1'b1);
    send_obs(EST_MAX, 1'b0);
    drain_results();

    // New initial values must not take effect without a restart.
    set_config(VAR_ONE, RST_PROC_VARIANCE, EST_MIN, 32'd1 << 20);
    send_obs('0, 1'b0);
    drain_results();
  endtask

  // Phases of random configuration. Most observations track a true value with
  // noise, which lets the variance settle and the gain shrink; the rest are
  // full-range noise, jumps of the true value, and random restarts.
  task automatic test_random_tracking();
    int phase, n;
    logic signed [DATA_W-1:0] truth;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      set_config(pick_variance(), pick_variance(), $urandom, pick_variance());
      rx_mode = rx_mode_t'(phase % 4);
      max_gap = (phase == 2) ? 0 : $urandom_range(1, 15);
      truth = $signed($urandom) >>> 1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 39) == 0) begin
          truth = $signed($urandom) >>> 1;
        end
        send_obs(next_reading(truth),
                 (n == 0 && phase[0]) || $urandom_range(0, 24) == 0);
      end
    end
    drain_results();
  endtask

  // The result side holds off for a long stretch while observations keep coming,
  // so the output register fills and the filter stops taking input.
  task automatic test_backpressure();
    int n;
    logic signed [DATA_W-1:0] truth;
    set_config(pick_variance(), DATA_W'($urandom_range(0, 1 << 16)), $urandom, VAR_ONE);
    rx_mode = RX_RANDOM;
    max_gap = 4;
    truth = $signed($urandom) >>> 1;
    hold_cycles = LONG_HOLD;
    for (n = 0; n < 40; n++) begin
      send_obs(next_reading(truth), n == 0);
    end
    drain_results();
  endtask

  // Back-to-back transactions with the result side always ready.
  task automatic test_full_rate();
    int n;
    logic signed [DATA_W-1:0] truth;
    set_config(pick_variance(), pick_variance(), $urandom, pick_variance());
    rx_mode = RX_ALWAYS;
    max_gap = 0;
    truth = $signed($urandom) >>> 1;
    for (n = 0; n < 200; n++) begin
      send_obs(next_reading(truth), n == 0 || $urandom_range(0, 29) == 0);
    end
    drain_results();
  endtask

  // Result monitor: checks each result transaction against the oldest expectation
  // and drives ready from the current throttling mode or the long hold.
  initial begin : result_monitor
    kf_result_t  want;
    int unsigned tick;
    tick = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        if (estimates_due.size() == 0) begin
          $error("unexpected result transaction: estimate %0d gain %0d error_variance %0d",
                 res_ch.estimate, res_ch.gain, res_ch.error_variance);
          fail_count++;
        end else begin
          want = estimates_due.pop_front();
          if (res_ch.estimate !== want.estimate) begin
            $error("estimate mismatch: expected %0d, actual %0d",
                   want.estimate, res_ch.estimate);
            fail_count++;
          end
          if (res_ch.gain !== want.gain) begin
            $error("gain mismatch: expected %0d, actual %0d", want.gain, res_ch.gain);
            fail_count++;
          end
          if (res_ch.error_variance !== want.error_variance) begin
            $error("error_variance mismatch: expected %0d, actual %0d",
                   want.error_variance, res_ch.error_variance);
            fail_count++;
          end
        end
      end
      tick++;
      if (hold_cycles > 0) begin
        hold_cycles--;
        res_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:   res_ch.ready <= 1'b1;
          RX_RANDOM:   res_ch.ready <= ($urandom_range(0, 2) != 0);
          RX_PERIODIC: res_ch.ready <= ((tick % 7) >= 3);
          default:     res_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_OBS_VARIANCE;
    cfg_data <= '0;
    obs_ch.valid <= 1'b0;
    obs_ch.observation <= '0;
    obs_ch.restart <= 1'b0;
    reset_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_config_extremes();
    test_random_tracking();
    test_backpressure();
    test_full_rate();

    // Everything has been checked; give a stray result time to show up.
    drain_results();
    repeat (2 * STEP_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> scalar_kalman_filter.f
design/skf_pkg.sv
design/skf_if.sv
design/scalar_kalman_filter.sv
design/skf_checker.sv
bench/tb.sv
